// File: rtl/core/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int COLOR_W = 4;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0020;

  typedef enum logic {
    ACT_PUT  = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  typedef enum logic {
    CFG_FOREGROUND = 1'b0,
    CFG_BACKGROUND = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MEM_IDLE,
    MEM_READ,
    MEM_WRITE
  } mem_op_e;

  typedef enum logic [1:0] {
    ASEL_CURSOR,
    ASEL_INDEX,
    ASEL_SWEEP_SRC,
    ASEL_SWEEP
  } addr_sel_e;

  typedef enum logic [1:0] {
    WSEL_PUT,
    WSEL_PAINT,
    WSEL_COPY,
    WSEL_BLANK
  } wdata_sel_e;

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic              line_advanced;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [ADDR_W-1:0] cursor_address;
    logic [CELL_W-1:0] cell_value;
  } out_word_t;

  typedef struct packed {
    mem_op_e    mem_op;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    logic       load_item;
    logic       col_inc;
    logic       line_next;
    logic       set_adv;
    logic       sweep_clr;
    logic       sweep_inc;
    logic       load_result;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_newline;
    logic index_ok;
    logic col_last;
    logic row_last;
    logic sweep_copy_last;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

// File: rtl/core/tcw_intf.sv
interface tcw_in_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [CHAR_W-1:0] char_code;
  logic [ADDR_W-1:0] cell_index;
  modport source (output valid, action, char_code, cell_index, input ready);
  modport sink   (input valid, action, char_code, cell_index, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic              line_advanced;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_row;
  logic [ADDR_W-1:0] cursor_address;
  logic [CELL_W-1:0] cell_value;
  modport source (output valid, line_advanced, cursor_column, cursor_row, cursor_address,
                  cell_value, input ready);
  modport sink   (input valid, line_advanced, cursor_column, cursor_row, cursor_address,
                  cell_value, output ready);
endinterface

interface tcw_cfg_if;
  import tcw_pkg::*;
  logic               valid;
  logic               ready;
  logic               index;
  logic [COLOR_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/tcw_datapath.sv
module tcw_datapath
  import tcw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  in_word_t           in_word_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [COLOR_W-1:0] cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_word_o
);

  logic [CELL_W-1:0]  mem [CELL_COUNT];
  logic [CELL_W-1:0]  rdata_q;

  in_word_t           item_q;
  logic               adv_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [ADDR_W-1:0]  row_base_q;
  logic [ADDR_W-1:0]  sweep_q;
  logic [COLOR_W-1:0] fg_q;
  logic [COLOR_W-1:0] bg_q;
  logic               out_valid_q;
  out_word_t          out_q;

  logic [ADDR_W-1:0]  cursor_addr;
  logic [ADDR_W-1:0]  mem_addr;
  logic [CELL_W-1:0]  mem_wdata;
  logic [CHAR_W-1:0]  attr;

  assign cursor_addr = row_base_q + ADDR_W'(col_q);
  assign attr        = {bg_q, fg_q};

  always_comb begin
    unique case (cmd_i.addr_sel)
      ASEL_CURSOR:    mem_addr = cursor_addr;
      ASEL_INDEX:     mem_addr = item_q.cell_index;
      ASEL_SWEEP_SRC: mem_addr = sweep_q + ADDR_W'(COLUMNS);
      ASEL_SWEEP:     mem_addr = sweep_q;
      default:        mem_addr = sweep_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wdata_sel)
      WSEL_PUT:   mem_wdata = {attr, item_q.char_code};
      WSEL_PAINT: mem_wdata = {attr, rdata_q[CHAR_W-1:0]};
      WSEL_COPY:  mem_wdata = rdata_q;
      WSEL_BLANK: mem_wdata = BLANK_CELL;
      default:    mem_wdata = BLANK_CELL;
    endcase
  end

  // single-port cell store, registered read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_op == MEM_WRITE) begin
      mem[mem_addr] <= mem_wdata;
    end else if (cmd_i.mem_op == MEM_READ) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_word_i;
    end
    if (cmd_i.load_item) begin
      adv_q <= 1'b0;
    end else if (cmd_i.set_adv) begin
      adv_q <= 1'b1;
    end
    if (cmd_i.load_result) begin
      out_q.line_advanced  <= adv_q;
      out_q.cursor_column  <= col_q;
      out_q.cursor_row     <= row_q;
      out_q.cursor_address <= cursor_addr;
      out_q.cell_value     <= (item_q.action == ACT_READ && status_o.index_ok) ?
                              rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      row_base_q  <= '0;
      sweep_q     <= '0;
      fg_q        <= COLOR_W'(7);
      bg_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.line_next) begin
        col_q <= '0;
        // on the last row the cursor stays put and the screen scrolls instead
        if (row_q != ROW_W'(ROWS - 1)) begin
          row_q      <= row_q + ROW_W'(1);
          row_base_q <= row_base_q + ADDR_W'(COLUMNS);
        end
      end else if (cmd_i.col_inc) begin
        col_q <= col_q + COL_W'(1);
      end

      if (cmd_i.sweep_clr) begin
        sweep_q <= '0;
      end else if (cmd_i.sweep_inc) begin
        sweep_q <= sweep_q + ADDR_W'(1);
      end

      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_FOREGROUND: fg_q <= cfg_data_i;
          CFG_BACKGROUND: bg_q <= cfg_data_i;
          default:        fg_q <= fg_q;
        endcase
      end

      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.is_read         = (item_q.action == ACT_READ);
    status_o.is_newline      = (item_q.char_code == NEWLINE_CODE);
    status_o.index_ok        = (item_q.cell_index < ADDR_W'(CELL_COUNT));
    status_o.col_last        = (col_q == COL_W'(COLUMNS - 1));
    status_o.row_last        = (row_q == ROW_W'(ROWS - 1));
    status_o.sweep_copy_last = (sweep_q == ADDR_W'(CELL_COUNT - COLUMNS - 1));
    status_o.sweep_last      = (sweep_q == ADDR_W'(CELL_COUNT - 1));
    status_o.out_free        = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < COL_W'(COLUMNS) && row_q < ROW_W'(ROWS))
    else $error("cursor out of screen");
  a_row_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_base_q == ADDR_W'(row_q * COLUMNS))
    else $error("row base out of step with row");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load_result && out_valid_q && !out_ready_i))
    else $error("result overwrites a word not yet taken");
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_result |=> out_valid_q)
    else $error("loaded result not presented");
`endif

endmodule

// File: rtl/core/tcw_ctrl.sv
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_PUT,
    ST_NEWLINE,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_BLANK,
    ST_PAINT_RD,
    ST_PAINT_WR,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.mem_op    = MEM_IDLE;
    cmd_o.addr_sel  = ASEL_CURSOR;
    cmd_o.wdata_sel = WSEL_BLANK;

    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.mem_op    = MEM_WRITE;
        cmd_o.addr_sel  = ASEL_SWEEP;
        cmd_o.wdata_sel = WSEL_BLANK;
        cmd_o.sweep_inc = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (status_i.is_read) begin
          state_d = ST_READ;
        end else if (status_i.is_newline) begin
          state_d = ST_NEWLINE;
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_READ: begin
        if (status_i.index_ok) begin
          cmd_o.mem_op   = MEM_READ;
          cmd_o.addr_sel = ASEL_INDEX;
        end
        state_d = ST_DONE;
      end
      ST_PUT: begin
        cmd_o.mem_op    = MEM_WRITE;
        cmd_o.addr_sel  = ASEL_CURSOR;
        cmd_o.wdata_sel = WSEL_PUT;
        if (status_i.col_last) begin
          cmd_o.line_next = 1'b1;
          cmd_o.set_adv   = 1'b1;
          cmd_o.sweep_clr = status_i.row_last;
          state_d = status_i.row_last ? ST_SCROLL_RD : ST_PAINT_RD;
        end else begin
          cmd_o.col_inc = 1'b1;
          state_d = ST_PAINT_RD;
        end
      end
      ST_NEWLINE: begin
        cmd_o.line_next = 1'b1;
        cmd_o.set_adv   = 1'b1;
        cmd_o.sweep_clr = status_i.row_last;
        state_d = status_i.row_last ? ST_SCROLL_RD : ST_PAINT_RD;
      end
      ST_SCROLL_RD: begin
        cmd_o.mem_op   = MEM_READ;
        cmd_o.addr_sel = ASEL_SWEEP_SRC;
        state_d = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        // move one cell up a row
        cmd_o.mem_op    = MEM_WRITE;
        cmd_o.addr_sel  = ASEL_SWEEP;
        cmd_o.wdata_sel = WSEL_COPY;
        cmd_o.sweep_inc = 1'b1;
        state_d = status_i.sweep_copy_last ? ST_BLANK : ST_SCROLL_RD;
      end
      ST_BLANK: begin
        cmd_o.mem_op    = MEM_WRITE;
        cmd_o.addr_sel  = ASEL_SWEEP;
        cmd_o.wdata_sel = WSEL_BLANK;
        cmd_o.sweep_inc = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_PAINT_RD;
        end
      end
      ST_PAINT_RD: begin
        cmd_o.mem_op   = MEM_READ;
        cmd_o.addr_sel = ASEL_CURSOR;
        state_d = ST_PAINT_WR;
      end
      ST_PAINT_WR: begin
        // recolor the cell under the cursor, keep its character
        cmd_o.mem_op    = MEM_WRITE;
        cmd_o.addr_sel  = ASEL_CURSOR;
        cmd_o.wdata_sel = WSEL_PAINT;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the word
        if (status_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_ready_o)
    else $error("item accepted during clearing pass");
  a_scroll_after_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL_RD && $past(state_q) != ST_SCROLL_WR) |-> $past(cmd_o.line_next))
    else $error("scroll started without a line advance");
  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |-> status_i.out_free)
    else $error("result loaded into a busy output register");
`endif

endmodule

// File: rtl/core/text_console_writer.sv
// Text console cell store, COLUMNS x ROWS cells of 16 bits (attribute in the high byte,
// character in the low byte) with a cursor. One item is worked at a time by a controller
// over a single-port cell memory. A put or newline that scrolls moves every cell up a row,
// each at the cost of one memory read and one memory write, then blanks the bottom row one
// cell a cycle. After reset a clearing pass fills all COLUMNS*ROWS cells with blanks
// before the first item is taken; configuration writes are taken at any time.
// A result waits in an output register, so the next item may be accepted before it is
// taken. Color registers: index 0 foreground, index 1 background; they apply from the
// next put.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tcw_in_if.sink    in_i,
  tcw_cfg_if.sink   cfg_i,
  tcw_out_if.source out_o
);

  cmd_t      cmd;
  status_t   status;
  in_word_t  in_word;
  out_word_t out_word;
  logic      in_ready;
  logic      out_valid;

  assign in_word.action     = in_i.action;
  assign in_word.char_code  = in_i.char_code;
  assign in_word.cell_index = in_i.cell_index;
  assign in_i.ready         = in_ready;

  assign cfg_i.ready = 1'b1;

  assign out_o.valid          = out_valid;
  assign out_o.line_advanced  = out_word.line_advanced;
  assign out_o.cursor_column  = out_word.cursor_column;
  assign out_o.cursor_row     = out_word.cursor_row;
  assign out_o.cursor_address = out_word.cursor_address;
  assign out_o.cell_value     = out_word.cell_value;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_word_i   (in_word),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_word)
  );

endmodule
